// ===== rtl/core/lkv_pkg.sv =====
// shared types and constants for the lru key/value cache
package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam int KV_W  = KEY_W + VAL_W;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // action codes carried in the input tuser
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_DEC,
        S_UPD,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/lkv_ram.sv =====
// generic single write port ram with registered read
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// lru key/value cache: top level with sweep sequencer and shared compare unit
// sequence: a get searches the entries, updates the ranks on a hit and then gives its result
//   (a miss skips the rank update); a put searches, writes and updates the ranks, with no result word
// throughput: one word at a time, set by the one-entry-per-cycle ram sweeps (search, then rank update)
// reset: valid bits, occupancy and the sequencer clear at once, capacity returns to 16;
//   key, value and rank rams are not cleared and need no clearing pass
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [63:0]        i_s_axis_tdata,   // lookup_key[31:0], write_value[63:32]
    input  logic [0:0]         i_s_axis_tuser,   // action[0]
    // result words
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [31:0]        o_m_axis_tdata,   // read_value[31:0]
    output logic [0:0]         o_m_axis_tuser,   // hit[0]
    // capacity register write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CAP_W-1:0]   i_cfg_data
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_pv;
    logic [IDX_W-1:0]  r_pidx;
    logic              r_act;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_wval;

    logic              r_hit_fnd;
    logic [IDX_W-1:0]  r_hit_idx;
    logic [RANK_W-1:0] r_hit_rank;
    logic [VAL_W-1:0]  r_hit_val;
    logic              r_vic_fnd;
    logic [IDX_W-1:0]  r_vic_idx;
    logic [RANK_W-1:0] r_vic_rank;
    logic              r_free_fnd;
    logic [IDX_W-1:0]  r_free_idx;

    logic [IDX_W-1:0]  r_tgt_idx;
    logic [RANK_W-1:0] r_tgt_rank;
    logic              r_age_all;

    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_occ;
    logic [CAP_W-1:0]   r_cap;

    logic              r_res_hit;
    logic [VAL_W-1:0]  r_res_val;
    logic              r_out_vld;
    logic              r_out_hit;
    logic [VAL_W-1:0]  r_out_val;

    // ram ports
    logic              kv_we;
    logic [IDX_W-1:0]  kv_waddr;
    logic [KV_W-1:0]   kv_rdata;
    logic              rk_we;
    logic [RANK_W-1:0] rk_wdata;
    logic [RANK_W-1:0] rk_rdata;
    logic [IDX_W-1:0]  rd_addr;

    // shared compare unit and sweep control
    logic              sweep_end;
    logic              cur_valid;
    logic              key_match;
    logic              put_full;
    logic              out_free;
    logic [CMP_W-1:0]  eff_cap;
    logic [CMP_W-1:0]  occ_ext;

    assign rd_addr   = r_cnt[IDX_W-1:0];
    assign sweep_end = (r_cnt == CNT_W'(ENTRIES)) && !r_pv;
    assign cur_valid = r_valid[r_pidx];
    assign key_match = cur_valid && (kv_rdata[KEY_W-1:0] == r_key);
    assign out_free  = !r_out_vld || i_m_axis_tready;
    assign occ_ext   = CMP_W'(r_occ);
    assign put_full  = occ_ext >= eff_cap;

    // effective capacity: clamp to 1..ENTRIES
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = CMP_W'(r_cap);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (sweep_end) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (r_act == ACT_GET && !r_hit_fnd) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (sweep_end) begin
                    n_state = (r_act == ACT_GET) ? S_DONE : S_IDLE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ram write controls and handshake outputs
    always_comb begin
        kv_we    = 1'b0;
        kv_waddr = r_free_idx;
        rk_we    = 1'b0;
        rk_wdata = '0;
        case (r_state)
            S_DEC: begin
                if (r_act == ACT_PUT) begin
                    kv_we = 1'b1;
                    if (r_hit_fnd) begin
                        kv_waddr = r_hit_idx;
                    end else if (put_full) begin
                        kv_waddr = r_vic_idx;
                    end else begin
                        kv_waddr = r_free_idx;
                    end
                end
            end
            S_UPD: begin
                if (r_pv) begin
                    if (r_pidx == r_tgt_idx) begin
                        rk_we    = 1'b1;
                        rk_wdata = '0;
                    end else if (cur_valid && (r_age_all || rk_rdata < r_tgt_rank)) begin
                        rk_we    = 1'b1;
                        rk_wdata = rk_rdata + RANK_W'(1);
                    end
                end
            end
            default: begin
                kv_we = 1'b0;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_val;
    assign o_m_axis_tuser  = r_out_hit;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_valid   <= '0;
            r_occ     <= '0;
            r_cap     <= CAP_RESET;
            r_out_vld <= 1'b0;
            r_hit_fnd <= 1'b0;
            r_vic_fnd <= 1'b0;
            r_free_fnd <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end

            // sweep counter and registered-read valid flag
            if (r_state == S_SRCH || r_state == S_UPD) begin
                if (r_cnt != CNT_W'(ENTRIES)) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_pv  <= 1'b1;
                end else begin
                    r_pv  <= 1'b0;
                end
            end else begin
                r_cnt <= '0;
                r_pv  <= 1'b0;
            end

            // search flags
            if (r_state == S_IDLE) begin
                r_hit_fnd  <= 1'b0;
                r_vic_fnd  <= 1'b0;
                r_free_fnd <= 1'b0;
            end else if (r_state == S_SRCH && r_pv) begin
                if (key_match && !r_hit_fnd) begin
                    r_hit_fnd <= 1'b1;
                end
                if (cur_valid) begin
                    r_vic_fnd <= 1'b1;
                end
                if (!cur_valid) begin
                    r_free_fnd <= 1'b1;
                end
            end

            // fill of a free slot
            if (r_state == S_DEC && r_act == ACT_PUT && !r_hit_fnd && !put_full) begin
                r_valid[r_free_idx] <= 1'b1;
                r_occ               <= r_occ + CNT_W'(1);
            end

            // result register
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx <= rd_addr;

        // capture the accepted word
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_act  <= i_s_axis_tuser[0];
            r_key  <= i_s_axis_tdata[KEY_W-1:0];
            r_wval <= i_s_axis_tdata[KV_W-1:KEY_W];
        end

        // compare unit: hit, oldest entry and first free slot
        if (r_state == S_SRCH && r_pv) begin
            if (key_match && !r_hit_fnd) begin
                r_hit_idx  <= r_pidx;
                r_hit_rank <= rk_rdata;
                r_hit_val  <= kv_rdata[KV_W-1:KEY_W];
            end
            if (cur_valid && (!r_vic_fnd || rk_rdata > r_vic_rank)) begin
                r_vic_idx  <= r_pidx;
                r_vic_rank <= rk_rdata;
            end
            if (!cur_valid && !r_free_fnd) begin
                r_free_idx <= r_pidx;
            end
        end

        // pick the entry to promote and the result
        if (r_state == S_DEC) begin
            r_res_hit <= r_hit_fnd;
            r_res_val <= r_hit_fnd ? r_hit_val : MISS_VALUE;
            if (r_hit_fnd) begin
                r_tgt_idx  <= r_hit_idx;
                r_tgt_rank <= r_hit_rank;
                r_age_all  <= 1'b0;
            end else if (put_full) begin
                r_tgt_idx  <= r_vic_idx;
                r_tgt_rank <= r_vic_rank;
                r_age_all  <= 1'b0;
            end else begin
                r_tgt_idx  <= r_free_idx;
                r_tgt_rank <= '0;
                r_age_all  <= 1'b1;
            end
        end

        if (r_state == S_DONE && out_free) begin
            r_out_hit <= r_res_hit;
            r_out_val <= r_res_val;
        end
    end

    // key and value store
    lkv_ram #(
        .WIDTH (KV_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_kv_ram (
        .i_clk   (i_clk),
        .i_we    (kv_we),
        .i_waddr (kv_waddr),
        .i_wdata ({r_wval, r_key}),
        .i_raddr (rd_addr),
        .o_rdata (kv_rdata)
    );

    // recency ranks, 0 is most recent
    lkv_ram #(
        .WIDTH (RANK_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rk_we),
        .i_waddr (r_pidx),
        .i_wdata (rk_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rk_rdata)
    );

endmodule
